// File: rtl/k_subset_enumerator_defines.svh
// ----------------------------------------------------------------------------
// k_subset_enumerator_defines: assertion macros
// Assertion helpers shared by the enumerator RTL. They can be removed by
// defining NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef K_SUBSET_ENUMERATOR_DEFINES_SVH
`define K_SUBSET_ENUMERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent holds in the same cycle as the antecedent.
`define KSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define KSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define KSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/kse_pkg.sv
// ----------------------------------------------------------------------------
// kse_pkg: shared types and constants of the k-subset enumerator
// Field widths, register reset values and configuration register indexes.
// ----------------------------------------------------------------------------
package kse_pkg;

  localparam int OUT_SLOTS = 8;
  localparam int ELEM_W    = 4;
  localparam int RANK_W    = 14;
  localparam int SET_W     = 5;
  localparam int PICK_W    = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [SET_W-1:0]  SET_SIZE_RST  = 5'd4;
  localparam logic [PICK_W-1:0] PICK_SIZE_RST = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_SIZE    = 1'b0,
    CFG_SUBSET_SIZE = 1'b1
  } cfg_reg_t;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [RANK_W-1:0] rank_t;

endpackage

// File: rtl/k_subset_enumerator.sv
// ----------------------------------------------------------------------------
// k_subset_enumerator: lexicographic k-subset generator
// Hands out the k-element subsets of {0..n-1} in lexicographic order, one
// per request beat, with rank, last flag and an empty flag when k is zero or k > n.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock and returns its result in the cycle
// after acceptance, so a steady stream runs at one subset per cycle while
// out_ready stays high. The successor logic checks every index against its
// bound in parallel and feeds the next subset back into the subset state. The
// result register is freed in the same cycle it is taken, so a stalled output
// only holds off requests while the result waits. Writing set_size or
// subset_size restarts the walk at the first subset.
`include "k_subset_enumerator_defines.svh"

module k_subset_enumerator
  import kse_pkg::*;
#(
  parameter int MAX_SET  = 16,
  parameter int MAX_PICK = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SET_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ELEM_W-1:0]    out_elem_0,
  output logic [ELEM_W-1:0]    out_elem_1,
  output logic [ELEM_W-1:0]    out_elem_2,
  output logic [ELEM_W-1:0]    out_elem_3,
  output logic [ELEM_W-1:0]    out_elem_4,
  output logic [ELEM_W-1:0]    out_elem_5,
  output logic [ELEM_W-1:0]    out_elem_6,
  output logic [ELEM_W-1:0]    out_elem_7,
  output logic [RANK_W-1:0]    out_rank,
  output logic                 out_last_subset,
  output logic                 out_empty_res
);

  localparam int IW  = (MAX_SET > 2) ? $clog2(MAX_SET) : 1;
  localparam int PW  = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int CW0 = $clog2(MAX_SET + MAX_PICK + 2) + 1;
  localparam int CW  = (CW0 > SET_W + 1) ? CW0 : SET_W + 1;

  typedef logic [IW-1:0] idx_t;
  typedef logic [CW-1:0] cmp_t;

  logic [SET_W-1:0]  set_size_r;
  logic [PICK_W-1:0] subset_size_r;
  idx_t              idx_r   [MAX_PICK];
  idx_t              idx_nxt [MAX_PICK];
  rank_t             rank_r;
  rank_t             rank_nxt;

  idx_t  first_idx [MAX_PICK];
  idx_t  cur_idx   [MAX_PICK];
  idx_t  succ_idx  [MAX_PICK];
  rank_t cur_rank;
  cmp_t  n_c;
  cmp_t  k_c;
  cmp_t  base_c;
  logic  [PW-1:0] pivot;
  logic  empty;
  logic  last;
  elem_t shown [OUT_SLOTS];

  logic  out_valid_r;
  elem_t out_elem_r [OUT_SLOTS];
  rank_t out_rank_r;
  logic  out_last_r;
  logic  out_empty_r;

  logic in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    n_c = (cmp_t'(set_size_r) > cmp_t'(MAX_SET)) ? cmp_t'(MAX_SET) : cmp_t'(set_size_r);
    k_c = (cmp_t'(subset_size_r) > cmp_t'(MAX_PICK)) ? cmp_t'(MAX_PICK)
                                                      : cmp_t'(subset_size_r);
    for (int i = 0; i < MAX_PICK; i++) begin
      first_idx[i] = idx_t'(i);
      cur_idx[i]   = in_restart ? first_idx[i] : idx_r[i];
    end
    cur_rank = in_restart ? '0 : rank_r;
    empty    = (k_c == '0) || (k_c > n_c);
    last     = (cmp_t'(cur_idx[0]) == n_c - k_c);

    pivot = '0;
    for (int x = 0; x < MAX_PICK; x++) begin
      if ((cmp_t'(x) < k_c) && (cmp_t'(cur_idx[x]) < n_c - k_c + cmp_t'(x))) begin
        pivot = PW'(x);
      end
    end
    base_c = cmp_t'(cur_idx[pivot]) + cmp_t'(1);

    for (int y = 0; y < MAX_PICK; y++) begin
      if (cmp_t'(y) > cmp_t'(pivot)) begin
        succ_idx[y] = idx_t'(base_c + cmp_t'(y) - cmp_t'(pivot));
      end else if (cmp_t'(y) == cmp_t'(pivot)) begin
        succ_idx[y] = idx_t'(base_c);
      end else begin
        succ_idx[y] = cur_idx[y];
      end
    end

    if (empty) begin
      idx_nxt  = cur_idx;
      rank_nxt = cur_rank;
    end else if (last) begin
      idx_nxt  = first_idx;
      rank_nxt = '0;
    end else begin
      idx_nxt  = succ_idx;
      rank_nxt = cur_rank + rank_t'(1);
    end
  end

  for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_slot
    if (j < MAX_PICK) begin : g_used
      assign shown[j] = (!empty && (cmp_t'(j) < k_c)) ? elem_t'(cur_idx[j]) : '0;
    end else begin : g_unused
      assign shown[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r    <= SET_SIZE_RST;
      subset_size_r <= PICK_SIZE_RST;
      idx_r         <= first_idx;
      rank_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_SIZE: begin
          set_size_r <= cfg_data;
          idx_r      <= first_idx;
          rank_r     <= '0;
        end
        CFG_SUBSET_SIZE: begin
          subset_size_r <= PICK_W'(cfg_data);
          idx_r         <= first_idx;
          rank_r        <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      idx_r  <= idx_nxt;
      rank_r <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_elem_r  <= shown;
      out_rank_r  <= empty ? '0 : cur_rank;
      out_last_r  <= !empty && last;
      out_empty_r <= empty;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_elem_0      = out_elem_r[0];
  assign out_elem_1      = out_elem_r[1];
  assign out_elem_2      = out_elem_r[2];
  assign out_elem_3      = out_elem_r[3];
  assign out_elem_4      = out_elem_r[4];
  assign out_elem_5      = out_elem_r[5];
  assign out_elem_6      = out_elem_r[6];
  assign out_elem_7      = out_elem_r[7];
  assign out_rank        = out_rank_r;
  assign out_last_subset = out_last_r;
  assign out_empty_res   = out_empty_r;

  `KSE_ASSERT_NOW(a_last_not_empty, clk, rst_n, out_valid_r && out_empty_r,
    !out_last_r && (out_rank_r == '0) && (out_elem_r[0] == '0),
    "Empty result carries a subset, rank or last flag.")

  `KSE_ASSERT_NEXT(a_rank_step, clk, rst_n,
    in_fire && !cfg_we && !in_restart && !empty && !last,
    rank_r == rank_t'($past(rank_r) + rank_t'(1)),
    "Rank did not advance by one after a plain request.")

  `KSE_ASSERT_NEXT(a_wrap_first, clk, rst_n,
    in_fire && !cfg_we && !empty && last,
    (rank_r == '0) && (idx_r[0] == '0),
    "Enumeration did not wrap to the first subset after the last one.")

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the k-subset enumerator
// Drives request beats with random bursts and gaps while the result side
// stalls on its own pattern. A model of the lexicographic walk predicts
// every result beat, and a checker compares each beat field by field.
// Directed tests cover reset values, restarts, empty results and oversized
// registers. A backpressure test and a long random run with many settings
// follow.
// ----------------------------------------------------------------------------
module tb_top;
  import kse_pkg::*;

  localparam int SET_LIMIT    = 16;
  localparam int PICK_LIMIT   = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int RANDOM_ITEMS = 800;
  localparam int WATCHDOG     = 12 * 300000;

  typedef struct packed {
    logic [OUT_SLOTS-1:0][ELEM_W-1:0] elem;
    rank_t                            rank;
    logic                             is_last;
    logic                             is_empty;
  } subset_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SET_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_restart;
  logic                 out_valid;
  logic                 out_ready;
  logic [ELEM_W-1:0]    out_elem_0;
  logic [ELEM_W-1:0]    out_elem_1;
  logic [ELEM_W-1:0]    out_elem_2;
  logic [ELEM_W-1:0]    out_elem_3;
  logic [ELEM_W-1:0]    out_elem_4;
  logic [ELEM_W-1:0]    out_elem_5;
  logic [ELEM_W-1:0]    out_elem_6;
  logic [ELEM_W-1:0]    out_elem_7;
  logic [RANK_W-1:0]    out_rank;
  logic                 out_last_subset;
  logic                 out_empty_res;

  logic [OUT_SLOTS-1:0][ELEM_W-1:0] got_elem;

  logic [SET_W-1:0]  model_set_size;
  logic [PICK_W-1:0] model_pick_size;
  int                walk_idx [PICK_LIMIT];
  rank_t             walk_rank;
  subset_t           pending_subsets [$];

  int error_count;
  int requests_sent;
  int results_seen;
  int lasts_seen;
  int empties_seen;
  int cfg_writes;
  int stalled_inputs;

  int       burst_left;
  bit       stream_open;
  bit       hold_req;
  int       hold_left;
  rx_mode_t rx_mode;
  int       rx_run;
  int       rx_tick;

  k_subset_enumerator #(
    .MAX_SET (SET_LIMIT),
    .MAX_PICK(PICK_LIMIT)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_elem_0     (out_elem_0),
    .out_elem_1     (out_elem_1),
    .out_elem_2     (out_elem_2),
    .out_elem_3     (out_elem_3),
    .out_elem_4     (out_elem_4),
    .out_elem_5     (out_elem_5),
    .out_elem_6     (out_elem_6),
    .out_elem_7     (out_elem_7),
    .out_rank       (out_rank),
    .out_last_subset(out_last_subset),
    .out_empty_res  (out_empty_res)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always_comb begin
    got_elem[0] = out_elem_0;
    got_elem[1] = out_elem_1;
    got_elem[2] = out_elem_2;
    got_elem[3] = out_elem_3;
    got_elem[4] = out_elem_4;
    got_elem[5] = out_elem_5;
    got_elem[6] = out_elem_6;
    got_elem[7] = out_elem_7;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic void restart_walk();
    for (int i = 0; i < PICK_LIMIT; i++) begin
      walk_idx[i] = i;
    end
    walk_rank = '0;
  endfunction

  function automatic subset_t predict_subset(input logic restart);
    subset_t res;
    int      n;
    int      k;
    int      x;
    res = '0;
    n = (model_set_size > SET_LIMIT) ? SET_LIMIT : int'(model_set_size);
    k = (model_pick_size > PICK_LIMIT) ? PICK_LIMIT : int'(model_pick_size);
    if (restart) begin
      restart_walk();
    end
    if (k == 0 || k > n) begin
      res.is_empty = 1'b1;
      return res;
    end
    for (int j = 0; j < k && j < OUT_SLOTS; j++) begin
      res.elem[j] = elem_t'(walk_idx[j]);
    end
    res.rank    = walk_rank;
    res.is_last = (walk_idx[0] == n - k);
    if (res.is_last) begin
      restart_walk();
    end else begin
      x = k;
      while (x > 0) begin
        x--;
        if (walk_idx[x] < n - k + x) begin
          walk_idx[x]++;
          for (int y = x + 1; y < k; y++) begin
            walk_idx[y] = walk_idx[y-1] + 1;
          end
          break;
        end
      end
      walk_rank = walk_rank + rank_t'(1);
    end
    return res;
  endfunction

  task automatic check_result();
    subset_t want;
    if (pending_subsets.size() == 0) begin
      report_mismatch("result beat with no request outstanding");
      return;
    end
    want = pending_subsets.pop_front();
    for (int i = 0; i < OUT_SLOTS; i++) begin
      if (got_elem[i] !== want.elem[i]) begin
        report_mismatch($sformatf("elem_%0d got %0d expected %0d at rank %0d",
                                  i, got_elem[i], want.elem[i], want.rank));
      end
    end
    if (out_rank !== want.rank) begin
      report_mismatch($sformatf("rank got %0d expected %0d", out_rank, want.rank));
    end
    if (out_last_subset !== want.is_last) begin
      report_mismatch($sformatf("last_subset got %b expected %b at rank %0d",
                                out_last_subset, want.is_last, want.rank));
    end
    if (out_empty_res !== want.is_empty) begin
      report_mismatch($sformatf("empty_res got %b expected %b",
                                out_empty_res, want.is_empty));
    end
    results_seen++;
    if (want.is_last) begin
      lasts_seen++;
    end
    if (want.is_empty) begin
      empties_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      model_set_size  = SET_SIZE_RST;
      model_pick_size = PICK_SIZE_RST;
      restart_walk();
    end else begin
      if (out_valid && out_ready) begin
        check_result();
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_SIZE: begin
            model_set_size = cfg_data;
          end
          CFG_SUBSET_SIZE: begin
            model_pick_size = cfg_data[PICK_W-1:0];
          end
          default: begin
          end
        endcase
        restart_walk();
      end
      if (in_valid && !in_ready) begin
        stalled_inputs++;
      end
      if (in_valid && in_ready) begin
        pending_subsets.push_back(predict_subset(in_restart));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_run  = $urandom_range(20, 80);
      end
      rx_run--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:     out_ready <= 1'b1;
        RX_RANDOM:   out_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_ready <= (rx_tick % 5 != 0);
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  task automatic send_request(input logic restart);
    int gap;
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid   <= 1'b0;
      stream_open = 1'b0;
      gap         = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4);
      burst_left  = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end else begin
      stream_open = 1'b1;
    end
  endtask

  task automatic wait_idle();
    if (stream_open) begin
      in_valid   <= 1'b0;
      stream_open = 1'b0;
    end
    while (pending_subsets.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [SET_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  task automatic test_reset_walk();
    // The reset setting is n = 4, k = 2: six subsets and then the wrap.
    repeat (7) send_request(1'b0);
  endtask

  task automatic test_restart();
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
  endtask

  task automatic test_empty_subset();
    write_reg(CFG_SET_SIZE, 5'd3);
    write_reg(CFG_SUBSET_SIZE, 5'd5);
    send_request(1'b0);
    send_request(1'b1);
    write_reg(CFG_SUBSET_SIZE, 5'd0);
    send_request(1'b0);
    write_reg(CFG_SET_SIZE, 5'd0);
    write_reg(CFG_SUBSET_SIZE, 5'd1);
    send_request(1'b0);
  endtask

  task automatic test_size_extremes();
    // Oversized registers are clamped to sixteen items and eight picks.
    write_reg(CFG_SET_SIZE, 5'd31);
    write_reg(CFG_SUBSET_SIZE, 5'd15);
    send_request(1'b0);
    send_request(1'b0);
    write_reg(CFG_SET_SIZE, 5'd1);
    write_reg(CFG_SUBSET_SIZE, 5'd1);
    send_request(1'b0);
    send_request(1'b0);
    write_reg(CFG_SET_SIZE, 5'd8);
    write_reg(CFG_SUBSET_SIZE, 5'd8);
    send_request(1'b0);
    write_reg(CFG_SET_SIZE, 5'd16);
    write_reg(CFG_SUBSET_SIZE, 5'd1);
    repeat (3) send_request(1'b0);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_SET_SIZE, 5'd6);
    write_reg(CFG_SUBSET_SIZE, 5'd3);
    burst_left = 40;
    hold_req   = 1'b1;
    repeat (30) send_request($urandom_range(0, 15) == 0);
  endtask

  task automatic test_random_walks();
    int                sent;
    int                phase_len;
    int                restart_odds;
    logic [SET_W-1:0]  n_val;
    logic [PICK_W-1:0] k_val;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          n_val = SET_W'($urandom_range(0, 31));
          k_val = PICK_W'($urandom_range(0, 15));
        end
        1: begin
          n_val = SET_W'($urandom_range(12, 16));
          k_val = PICK_W'($urandom_range(6, 8));
        end
        default: begin
          n_val = SET_W'($urandom_range(1, 8));
          k_val = PICK_W'($urandom_range(1, (n_val > 4) ? 4 : n_val));
        end
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(CFG_SET_SIZE, n_val);
        1: begin
          write_reg(CFG_SUBSET_SIZE, SET_W'(k_val));
          write_reg(CFG_SET_SIZE, n_val);
        end
        default: begin
          write_reg(CFG_SET_SIZE, n_val);
          write_reg(CFG_SUBSET_SIZE, SET_W'(k_val));
        end
      endcase
      phase_len    = $urandom_range(5, 50);
      restart_odds = ($urandom_range(0, 7) == 0) ? 2 : 20;
      repeat (phase_len) begin
        send_request($urandom_range(1, restart_odds) == 1);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_SET_SIZE;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_restart  = 1'b0;
    out_ready   = 1'b0;
    burst_left  = 4;
    stream_open = 1'b0;
    hold_req    = 1'b0;
    hold_left   = 0;
    rx_run      = 0;
    rx_tick     = 0;
    rx_mode     = RX_OPEN;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_walk();
    test_restart();
    test_empty_subset();
    test_size_extremes();
    test_backpressure();
    test_random_walks();
    wait_idle();
    $display("covered %0d requests and %0d results over %0d register writes",
             requests_sent, results_seen, cfg_writes);
    $display("saw %0d final subsets, %0d empty results, %0d stalled request cycles",
             lasts_seen, empties_seen, stalled_inputs);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG);
    $display("timeout with %0d results outstanding", pending_subsets.size());
    $display("status: fail");
    $finish;
  end

endmodule
